@@ rtl/ezr_pkg.sv @@
// Shared types, constants and the sin^2 weight function of the edge-zone relaxation source.
package ezr_pkg;

	localparam int LANES_DEF   = 3;
	localparam int DEPTH_DEF   = 256;
	localparam int FIELD_LANES = 3;
	localparam int COORD_W     = 24;
	localparam int DIST_W      = COORD_W + 1;
	localparam int THICK_W     = 23;
	localparam int D_W         = THICK_W + 1;
	localparam int VAL_W       = 32;
	localparam int DIFF_W      = VAL_W + 1;
	localparam int ALPHA_W     = 16;
	localparam int WEIGHT_W    = 17;
	localparam int GAIN_W      = 17;
	localparam int PROD_W      = DIFF_W + GAIN_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int IN_DATA_W   = 2 * COORD_W + 2 * FIELD_LANES * VAL_W;
	localparam int IN_USER_W   = 2;
	localparam int OUT_DATA_W  = FIELD_LANES * VAL_W;
	localparam int OUT_USER_W  = 4;

	localparam logic [THICK_W-1:0] THICK_RST   = 23'd15360;
	localparam logic [ALPHA_W-1:0] ALPHA_V_RST = 16'd19661;
	localparam logic [ALPHA_W-1:0] ALPHA_T_RST = 16'd6554;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q16     = 64'd65536;

	typedef enum logic [2:0] {
		ZONE_NONE  = 3'd0,
		ZONE_WEST  = 3'd1,
		ZONE_EAST  = 3'd2,
		ZONE_NORTH = 3'd3,
		ZONE_SOUTH = 3'd4
	} zone_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X   = 3'd0,
		REG_MAX_X   = 3'd1,
		REG_MIN_Y   = 3'd2,
		REG_MAX_Y   = 3'd3,
		REG_THICK   = 3'd4,
		REG_ALPHA_V = 3'd5,
		REG_ALPHA_T = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                                 mode;
		logic                                 target_valid;
		logic [COORD_W-1:0]                   cell_x;
		logic [COORD_W-1:0]                   cell_y;
		logic [FIELD_LANES-1:0][VAL_W-1:0]    value;
		logic [FIELD_LANES-1:0][VAL_W-1:0]    target;
	} item_t;

	typedef struct packed {
		logic                                 mode;
		logic                                 written;
		zone_t                                zone;
		logic                                 idx_top;
		logic                                 idx_zero;
		logic [FIELD_LANES-1:0]               neg;
		logic [FIELD_LANES-1:0][DIFF_W-1:0]   mag;
	} side_t;

	function automatic logic [63:0] taylor_mul(input logic [63:0] term, input logic [63:0] x2);
		return (term * x2) >> 30;
	endfunction

	// sin^2 of an angle given in Q2.30, result in Q1.16
	function automatic logic [WEIGHT_W-1:0] weight_from_x(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        t;
		logic [63:0]        s2;
		logic [63:0]        w;
		logic signed [63:0] s;
		x2 = (x * x) >> 30;
		t  = x;
		s  = signed'(x);
		t  = taylor_mul(t, x2) / 64'd6;
		s  = s - signed'(t);
		t  = taylor_mul(t, x2) / 64'd20;
		s  = s + signed'(t);
		t  = taylor_mul(t, x2) / 64'd42;
		s  = s - signed'(t);
		t  = taylor_mul(t, x2) / 64'd72;
		s  = s + signed'(t);
		t  = taylor_mul(t, x2) / 64'd110;
		s  = s - signed'(t);
		t  = taylor_mul(t, x2) / 64'd156;
		s  = s + signed'(t);
		t  = taylor_mul(t, x2) / 64'd210;
		s  = s - signed'(t);
		if (s < 0) begin
			s = '0;
		end
		s2 = unsigned'(s);
		w  = (s2 * s2 + (64'd1 << 43)) >> 44;
		if (w > ONE_Q16) begin
			w = ONE_Q16;
		end
		return w[WEIGHT_W-1:0];
	endfunction

endpackage

@@ rtl/ezr_zone.sv @@
// Zone classification, difference magnitudes and weight-index numerator (three stages).
module ezr_zone import ezr_pkg::*; #(
	parameter int WEIGHT_TABLE_DEPTH = DEPTH_DEF,
	parameter int NUM_W              = D_W + 9
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  item_t                      item,
	input  logic signed [COORD_W-1:0]  min_x,
	input  logic signed [COORD_W-1:0]  max_x,
	input  logic signed [COORD_W-1:0]  min_y,
	input  logic signed [COORD_W-1:0]  max_y,
	input  logic [D_W-1:0]             thick,
	output logic                       out_valid,
	output logic [NUM_W-1:0]           num,
	output logic [D_W-1:0]             thick_out,
	output side_t                      side
);

	logic                                   valid_s1, valid_s2, valid_s3;
	logic signed [DIST_W-1:0]               dw_s1, de_s1, ds_s1, dn_s1;
	logic [FIELD_LANES-1:0][DIFF_W-1:0]     diff_s1;
	logic                                   mode_s1, tv_s1;
	logic [D_W-1:0]                         thick_s1, thick_s2, thick_s3;

	zone_t                                  zone_c;
	logic signed [DIST_W-1:0]               dist_c;
	logic signed [DIST_W:0]                 dlim;
	logic [FIELD_LANES-1:0]                 neg_c;
	logic [FIELD_LANES-1:0][DIFF_W-1:0]     mag_c;

	zone_t                                  zone_s2;
	logic signed [DIST_W-1:0]               dist_s2;
	logic                                   top_s2, zero_s2, mode_s2, written_s2;
	logic [FIELD_LANES-1:0]                 neg_s2;
	logic [FIELD_LANES-1:0][DIFF_W-1:0]     mag_s2;

	logic [NUM_W-1:0]                       num_s3;
	side_t                                  side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dw_s1    <= DIST_W'(signed'(item.cell_x)) - DIST_W'(min_x);
			de_s1    <= DIST_W'(max_x) - DIST_W'(signed'(item.cell_x));
			ds_s1    <= DIST_W'(signed'(item.cell_y)) - DIST_W'(min_y);
			dn_s1    <= DIST_W'(max_y) - DIST_W'(signed'(item.cell_y));
			for (int k = 0; k < FIELD_LANES; k++) begin
				diff_s1[k] <= DIFF_W'(signed'(item.target[k])) - DIFF_W'(signed'(item.value[k]));
			end
			mode_s1  <= item.mode;
			tv_s1    <= item.target_valid;
			thick_s1 <= thick;
		end
	end

	assign dlim = {2'b00, thick_s1};

	always_comb begin
		zone_c = ZONE_NONE;
		dist_c = '0;
		if ((DIST_W+1)'(dw_s1) <= dlim && dw_s1 < ds_s1 && dw_s1 < dn_s1) begin
			zone_c = ZONE_WEST;
			dist_c = dw_s1;
		end else if ((DIST_W+1)'(de_s1) <= dlim && de_s1 < ds_s1 && de_s1 < dn_s1) begin
			zone_c = ZONE_EAST;
			dist_c = de_s1;
		end else if ((DIST_W+1)'(dn_s1) <= dlim && dn_s1 < dw_s1 && dn_s1 < de_s1) begin
			zone_c = ZONE_NORTH;
			dist_c = dn_s1;
		end else if ((DIST_W+1)'(ds_s1) <= dlim && ds_s1 < dw_s1 && ds_s1 < de_s1) begin
			zone_c = ZONE_SOUTH;
			dist_c = ds_s1;
		end
		for (int k = 0; k < FIELD_LANES; k++) begin
			neg_c[k] = diff_s1[k][DIFF_W-1];
			mag_c[k] = neg_c[k] ? (~diff_s1[k] + DIFF_W'(1)) : diff_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zone_s2    <= zone_c;
			dist_s2    <= dist_c;
			top_s2     <= dist_c <= 0;
			zero_s2    <= (DIST_W+1)'(dist_c) >= dlim;
			mode_s2    <= mode_s1;
			written_s2 <= (zone_c != ZONE_NONE) && tv_s1;
			neg_s2     <= neg_c;
			mag_s2     <= mag_c;
			thick_s2   <= thick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3 <= NUM_W'(thick_s2 - dist_s2[D_W-1:0]) * NUM_W'(WEIGHT_TABLE_DEPTH)
				+ NUM_W'(thick_s2 >> 1);
			thick_s3             <= thick_s2;
			side_s3.mode         <= mode_s2;
			side_s3.written      <= written_s2;
			side_s3.zone         <= zone_s2;
			side_s3.idx_top      <= top_s2;
			side_s3.idx_zero     <= zero_s2;
			side_s3.neg          <= neg_s2;
			side_s3.mag          <= mag_s2;
		end
	end

	assign out_valid = valid_s3;
	assign num       = num_s3;
	assign thick_out = thick_s3;
	assign side      = side_s3;

endmodule

@@ rtl/ezr_div.sv @@
// Pipelined restoring divider for the weight index, one quotient bit per stage.
module ezr_div import ezr_pkg::*; #(
	parameter int QB    = 9,
	parameter int NUM_W = D_W + 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [D_W-1:0]    thick,
	input  side_t             side_in,
	output logic              out_valid,
	output logic [QB-1:0]     quot,
	output side_t             side_out
);

	logic [NUM_W-1:0] rem_s   [QB];
	logic [QB-1:0]    quot_s  [QB];
	logic [D_W-1:0]   thick_s [QB];
	side_t            side_s  [QB];
	logic [QB-1:0]    valid_s;

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int B = QB - 1 - j;
		logic [NUM_W-1:0] rem_in;
		logic [QB-1:0]    quot_in;
		logic [D_W-1:0]   thick_in;
		side_t            side_i;
		logic             valid_in;
		logic [NUM_W-1:0] div_sh;
		logic             ge;

		if (j == 0) begin : g_first
			assign rem_in   = num;
			assign quot_in  = '0;
			assign thick_in = thick;
			assign side_i   = side_in;
			assign valid_in = in_valid;
		end else begin : g_next
			assign rem_in   = rem_s[j-1];
			assign quot_in  = quot_s[j-1];
			assign thick_in = thick_s[j-1];
			assign side_i   = side_s[j-1];
			assign valid_in = valid_s[j-1];
		end

		assign div_sh = NUM_W'(thick_in) << B;
		assign ge     = rem_in >= div_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en) begin
				valid_s[j] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]   <= ge ? (rem_in - div_sh) : rem_in;
				quot_s[j]  <= quot_in | (QB'(ge) << B);
				thick_s[j] <= thick_in;
				side_s[j]  <= side_i;
			end
		end
	end

	assign out_valid = valid_s[QB-1];
	assign quot      = quot_s[QB-1];
	assign side_out  = side_s[QB-1];

endmodule

@@ rtl/ezr_lane.sv @@
// One source lane: magnitude times gain, rounding half away from zero, saturation.
module ezr_lane import ezr_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [GAIN_W-1:0]  gain,
	input  logic               neg,
	input  logic [DIFF_W-1:0]  mag,
	output logic [VAL_W-1:0]   source
);

	localparam int Q_W = PROD_W + 1 - 16;
	localparam logic [Q_W-1:0]   POS_LIM = Q_W'(32'h7FFF_FFFF);
	localparam logic [Q_W-1:0]   NEG_LIM = Q_W'(32'h8000_0000);
	localparam logic [VAL_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] NEG_MAX = 32'h8000_0000;

	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1;
	logic [PROD_W:0]   rnd;
	logic [Q_W-1:0]    q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(gain);
			neg_s1  <= neg;
		end
	end

	assign rnd = (PROD_W+1)'(prod_s1) + (PROD_W+1)'(32'h8000);
	assign q   = rnd[PROD_W:16];

	always_comb begin
		if (!neg_s1) begin
			source = (q > POS_LIM) ? POS_MAX : q[VAL_W-1:0];
		end else begin
			source = (q > NEG_LIM) ? NEG_MAX : (~q[VAL_W-1:0] + VAL_W'(1));
		end
	end

endmodule

@@ rtl/edge_zone_relaxation_source_unit.sv @@
// Top level of the edge-zone relaxation source: config, input skid, pipeline, lanes, output.
//
//  channel   direction  signals                              request carries
//  s_axis    in         tvalid tready tdata[239:0] tuser[1:0] one grid cell
//  m_axis    out        tvalid tready tdata[95:0] tuser[3:0]  one source result
//  cfg       in         valid ready index[2:0] data[23:0]     one register write
//
//  One cell per clock while the output is not stalled; the path runs through the zone stages,
//  the one-bit-per-stage divider that forms the weight index, weight lookup, gain, lanes and output.
//  Reset clears the valid bits and loads the register defaults; no clearing pass.
//  A stalled output freezes the whole pipeline; a skid register keeps s_axis_tready registered.
//  cfg_ready is always high.
module edge_zone_relaxation_source_unit import ezr_pkg::*; #(
	parameter int LANES              = LANES_DEF,
	parameter int WEIGHT_TABLE_DEPTH = DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// cell_x, cell_y, value_0, value_1, value_2, target_0, target_1, target_2
	input  logic [IN_DATA_W-1:0]    s_axis_tdata,
	// mode, target_valid
	input  logic [IN_USER_W-1:0]    s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// source_0, source_1, source_2
	output logic [OUT_DATA_W-1:0]   m_axis_tdata,
	// zone[2:0], written
	output logic [OUT_USER_W-1:0]   m_axis_tuser,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int QB    = $clog2(WEIGHT_TABLE_DEPTH + 1);
	localparam int NUM_W = D_W + QB;

	logic signed [COORD_W-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic [THICK_W-1:0]        thick_q;
	logic [ALPHA_W-1:0]        alpha_v_q, alpha_t_q;
	logic [D_W-1:0]            thick_eff;

	item_t                     port_item, skid_q, head;
	logic                      skid_full_q, head_valid, en;

	logic                      zone_valid;
	logic [NUM_W-1:0]          zone_num;
	logic [D_W-1:0]            zone_thick;
	side_t                     zone_side;

	logic                      div_valid;
	logic [QB-1:0]             div_quot;
	side_t                     div_side;

	logic [WEIGHT_W-1:0]       weight_rom [0:WEIGHT_TABLE_DEPTH];
	logic [QB-1:0]             idx;
	logic                      valid_s1, valid_s2, valid_s3;
	logic [WEIGHT_W-1:0]       weight_s1;
	side_t                     side_s1, side_s2, side_s3;
	logic [GAIN_W-1:0]         gain_s2;
	logic [ALPHA_W-1:0]        alpha;
	logic [ALPHA_W+WEIGHT_W:0] gain_sum;

	logic [FIELD_LANES-1:0][VAL_W-1:0] lane_src;
	logic [FIELD_LANES-1:0][VAL_W-1:0] src_q;
	logic                      out_valid_q;
	zone_t                     zone_q;
	logic                      written_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q   <= '0;
			max_x_q   <= '0;
			min_y_q   <= '0;
			max_y_q   <= '0;
			thick_q   <= THICK_RST;
			alpha_v_q <= ALPHA_V_RST;
			alpha_t_q <= ALPHA_T_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_MIN_X: begin
					min_x_q <= cfg_data;
				end
				REG_MAX_X: begin
					max_x_q <= cfg_data;
				end
				REG_MIN_Y: begin
					min_y_q <= cfg_data;
				end
				REG_MAX_Y: begin
					max_y_q <= cfg_data;
				end
				REG_THICK: begin
					thick_q <= cfg_data[THICK_W-1:0];
				end
				REG_ALPHA_V: begin
					alpha_v_q <= cfg_data[ALPHA_W-1:0];
				end
				REG_ALPHA_T: begin
					alpha_t_q <= cfg_data[ALPHA_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// zero thickness acts as one LSB
	assign thick_eff = (thick_q == '0) ? D_W'(1) : {1'b0, thick_q};

	always_comb begin
		port_item.mode         = s_axis_tuser[0];
		port_item.target_valid = s_axis_tuser[1];
		port_item.cell_x       = s_axis_tdata[COORD_W-1:0];
		port_item.cell_y       = s_axis_tdata[2*COORD_W-1:COORD_W];
		for (int k = 0; k < FIELD_LANES; k++) begin
			port_item.value[k]  = s_axis_tdata[2*COORD_W + k*VAL_W +: VAL_W];
			port_item.target[k] = s_axis_tdata[2*COORD_W + (FIELD_LANES+k)*VAL_W +: VAL_W];
		end
	end

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !skid_full_q;
	assign head          = skid_full_q ? skid_q : port_item;
	assign head_valid    = skid_full_q || s_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (en) begin
			skid_full_q <= 1'b0;
		end else if (s_axis_tvalid && !skid_full_q) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_axis_tvalid && !skid_full_q) begin
			skid_q <= port_item;
		end
	end

	ezr_zone #(
		.WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH),
		.NUM_W              (NUM_W)
	) u_zone (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (head_valid),
		.item      (head),
		.min_x     (min_x_q),
		.max_x     (max_x_q),
		.min_y     (min_y_q),
		.max_y     (max_y_q),
		.thick     (thick_eff),
		.out_valid (zone_valid),
		.num       (zone_num),
		.thick_out (zone_thick),
		.side      (zone_side)
	);

	ezr_div #(
		.QB    (QB),
		.NUM_W (NUM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (zone_valid),
		.num       (zone_num),
		.thick     (zone_thick),
		.side_in   (zone_side),
		.out_valid (div_valid),
		.quot      (div_quot),
		.side_out  (div_side)
	);

	for (genvar i = 0; i <= WEIGHT_TABLE_DEPTH; i++) begin : g_rom
		localparam logic [63:0] X = (64'(i) * PI_HALF_Q30) / 64'(WEIGHT_TABLE_DEPTH);
		assign weight_rom[i] = weight_from_x(X);
	end

	always_comb begin
		if (div_side.idx_top) begin
			idx = QB'(WEIGHT_TABLE_DEPTH);
		end else if (div_side.idx_zero) begin
			idx = '0;
		end else if (div_quot > QB'(WEIGHT_TABLE_DEPTH)) begin
			idx = QB'(WEIGHT_TABLE_DEPTH);
		end else begin
			idx = div_quot;
		end
	end

	assign alpha    = side_s1.mode ? alpha_t_q : alpha_v_q;
	assign gain_sum = (ALPHA_W+WEIGHT_W+1)'(alpha) * (ALPHA_W+WEIGHT_W+1)'(weight_s1)
		+ (ALPHA_W+WEIGHT_W+1)'(32'h8000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= div_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			weight_s1 <= weight_rom[idx];
			side_s1   <= div_side;
			gain_s2   <= gain_sum[GAIN_W+15:16];
			side_s2   <= side_s1;
			side_s3   <= side_s2;
		end
	end

	for (genvar k = 0; k < FIELD_LANES; k++) begin : g_lane
		if (k < LANES) begin : g_on
			ezr_lane u_lane (
				.clk    (clk),
				.en     (en),
				.gain   (gain_s2),
				.neg    (side_s2.neg[k]),
				.mag    (side_s2.mag[k]),
				.source (lane_src[k])
			);
		end else begin : g_off
			assign lane_src[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < FIELD_LANES; k++) begin
				src_q[k] <= (side_s3.written && (k == 0 || !side_s3.mode)) ? lane_src[k] : '0;
			end
			zone_q    <= side_s3.zone;
			written_q <= side_s3.written;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = src_q;
	assign m_axis_tuser  = {written_q, zone_q};

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tdata == '0)
		else $error("unwritten result carries a nonzero source");

	a_written_has_zone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[3] |-> m_axis_tuser[2:0] != ZONE_NONE)
		else $error("written result without a zone");

	a_temp_single_lane: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s3 && side_s3.mode |=> m_axis_tdata[OUT_DATA_W-1:VAL_W] == '0)
		else $error("temperature result drives upper lanes");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> gain_s2 <= GAIN_W'(32'hFFFF))
		else $error("gain exceeds unity");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q && !en |=> skid_full_q && $stable(skid_q))
		else $error("skid entry lost while pipeline stalled");

endmodule

@@ bench/edge_zone_relaxation_source_unit_tb.sv @@
// Self-checking bench for the edge-zone relaxation source against a local predictor.
`timescale 1ns / 1ps

module edge_zone_relaxation_source_unit_tb;
	import ezr_pkg::*;

	localparam int LANE_COUNT = LANES_DEF;
	localparam int DEPTH      = DEPTH_DEF;
	localparam int LATENCY    = $clog2(DEPTH + 1) + 7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam longint COORD_MIN = -8388608;
	localparam longint COORD_MAX = 8388607;

	typedef struct packed {
		logic [FIELD_LANES-1:0][VAL_W-1:0] source;
		zone_t                             zone;
		logic                              written;
	} src_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// register mirror
	longint          zmin_x, zmax_x, zmin_y, zmax_y;
	longint          thick, gain_vel, gain_temp;
	logic [16:0]     sin2_lut [0:DEPTH];

	src_result_t     pending_sources [$];
	int              mismatches;
	int              cells_in;
	int              results_out;
	int              applied;
	int              settings_used;
	int              zone_hits [0:4];
	bit              no_idle;

	edge_zone_relaxation_source_unit #(
		.LANES(LANE_COUNT),
		.WEIGHT_TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sin^2 weight table in Q1.16 from a Q2.30 series
	initial begin
		longint unsigned ang, ang2, term, sq;
		longint          acc;
		for (int i = 0; i <= DEPTH; i++) begin
			ang  = 64'(i) * PI_HALF_Q30 / 64'(DEPTH);
			ang2 = (ang * ang) >> 30;
			term = ang;
			acc  = longint'(ang);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * ang2) >> 30) / 64'(2 * n * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			sq = longint'(acc);
			sq = (sq * sq + (64'd1 << 43)) >> 44;
			if (sq > 65536) begin
				sq = 65536;
			end
			sin2_lut[i] = sq[16:0];
		end
	end

	function automatic src_result_t relax_source(input item_t pt);
		src_result_t res;
		longint      x, y, d, dw, de, ds, dn, gap, idx, g, diff, mag, q, r;
		int          lanes;
		res      = '0;
		res.zone = ZONE_NONE;
		x    = longint'(signed'(pt.cell_x));
		y    = longint'(signed'(pt.cell_y));
		d    = (thick == 0) ? 1 : thick;
		dw   = x - zmin_x;
		de   = zmax_x - x;
		ds   = y - zmin_y;
		dn   = zmax_y - y;
		gap  = 0;
		if (dw <= d && dw < ds && dw < dn) begin
			res.zone = ZONE_WEST;
			gap      = dw;
		end else if (de <= d && de < ds && de < dn) begin
			res.zone = ZONE_EAST;
			gap      = de;
		end else if (dn <= d && dn < dw && dn < de) begin
			res.zone = ZONE_NORTH;
			gap      = dn;
		end else if (ds <= d && ds < dw && ds < de) begin
			res.zone = ZONE_SOUTH;
			gap      = ds;
		end
		if (res.zone == ZONE_NONE || !pt.target_valid) begin
			return res;
		end
		if (gap <= 0) begin
			idx = DEPTH;
		end else if (gap >= d) begin
			idx = 0;
		end else begin
			idx = ((d - gap) * DEPTH + d / 2) / d;
		end
		if (idx > DEPTH) begin
			idx = DEPTH;
		end
		g = ((pt.mode ? gain_temp : gain_vel) * longint'(sin2_lut[idx]) + 32768) >>> 16;
		lanes = pt.mode ? 1 : LANE_COUNT;
		if (lanes > FIELD_LANES) begin
			lanes = FIELD_LANES;
		end
		for (int k = 0; k < lanes; k++) begin
			diff = longint'(signed'(pt.target[k])) - longint'(signed'(pt.value[k]));
			mag  = (diff < 0) ? -diff : diff;
			q    = (mag * g + 32768) >>> 16;
			r    = (diff < 0) ? -q : q;
			if (r > 64'sd2147483647) begin
				r = 64'sd2147483647;
			end
			if (r < -64'sd2147483648) begin
				r = -64'sd2147483648;
			end
			res.source[k] = r[31:0];
		end
		res.written = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint want, input longint got);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
		mismatches++;
	endtask

	// mirror register writes, predict accepted cells, check delivered sources
	always @(posedge clk) begin : watch
		item_t       pt;
		src_result_t want, got;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_X:   zmin_x = longint'(signed'(cfg_data));
				REG_MAX_X:   zmax_x = longint'(signed'(cfg_data));
				REG_MIN_Y:   zmin_y = longint'(signed'(cfg_data));
				REG_MAX_Y:   zmax_y = longint'(signed'(cfg_data));
				REG_THICK:   thick = longint'(cfg_data[THICK_W-1:0]);
				REG_ALPHA_V: gain_vel = longint'(cfg_data[ALPHA_W-1:0]);
				REG_ALPHA_T: gain_temp = longint'(cfg_data[ALPHA_W-1:0]);
				default: ;
			endcase
		end
		if (s_axis_tvalid && s_axis_tready) begin
			pt.cell_x       = s_axis_tdata[23:0];
			pt.cell_y       = s_axis_tdata[47:24];
			pt.value[0]     = s_axis_tdata[79:48];
			pt.value[1]     = s_axis_tdata[111:80];
			pt.value[2]     = s_axis_tdata[143:112];
			pt.target[0]    = s_axis_tdata[175:144];
			pt.target[1]    = s_axis_tdata[207:176];
			pt.target[2]    = s_axis_tdata[239:208];
			pt.mode         = s_axis_tuser[0];
			pt.target_valid = s_axis_tuser[1];
			pending_sources.push_back(relax_source(pt));
			cells_in++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			got.source  = m_axis_tdata;
			got.zone    = zone_t'(m_axis_tuser[2:0]);
			got.written = m_axis_tuser[3];
			results_out++;
			if (pending_sources.size() == 0) begin
				report_mismatch("result with nothing pending", 0, 1);
			end else begin
				want = pending_sources.pop_front();
				zone_hits[want.zone]++;
				if (want.written) begin
					applied++;
				end
				for (int k = 0; k < FIELD_LANES; k++) begin
					if (got.source[k] !== want.source[k]) begin
						report_mismatch($sformatf("source_%0d", k),
							longint'(signed'(want.source[k])),
							longint'(signed'(got.source[k])));
					end
				end
				if (got.zone !== want.zone) begin
					report_mismatch("zone", want.zone, got.zone);
				end
				if (got.written !== want.written) begin
					report_mismatch("written", want.written, got.written);
				end
			end
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 29);
	end

	task automatic send_point(input item_t pt);
		if (!no_idle && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 29);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {pt.target[2], pt.target[1], pt.target[0],
			pt.value[2], pt.value[1], pt.value[0], pt.cell_y, pt.cell_x};
		s_axis_tuser  <= {pt.target_valid, pt.mode};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold the sender until every pending source has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_sources.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input longint mnx, input longint mxx, input longint mny,
			input longint mxy, input longint thk, input longint av, input longint at);
		settle();
		write_reg(REG_MIN_X, mnx[23:0]);
		write_reg(REG_MAX_X, mxx[23:0]);
		write_reg(REG_MIN_Y, mny[23:0]);
		write_reg(REG_MAX_Y, mxy[23:0]);
		write_reg(REG_THICK, thk[23:0]);
		write_reg(REG_ALPHA_V, av[23:0]);
		write_reg(REG_ALPHA_T, at[23:0]);
		settings_used++;
	endtask

	function automatic item_t mk(input bit md, input bit tv, input longint x, input longint y,
			input logic [31:0] val, input logic [31:0] tgt);
		item_t pt;
		pt.mode         = md;
		pt.target_valid = tv;
		pt.cell_x       = x[23:0];
		pt.cell_y       = y[23:0];
		for (int k = 0; k < FIELD_LANES; k++) begin
			pt.value[k]  = val + 32'(k) * 32'h0003_1000;
			pt.target[k] = tgt - 32'(k) * 32'h0002_0000;
		end
		return pt;
	endfunction

	function automatic longint rand_between(input longint a, input longint b);
		longint lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return lo + (longint'($urandom) % (hi - lo + 1));
	endfunction

	function automatic logic [23:0] clamp_coord(input longint v);
		if (v < COORD_MIN) begin
			v = COORD_MIN;
		end
		if (v > COORD_MAX) begin
			v = COORD_MAX;
		end
		return v[23:0];
	endfunction

	function automatic logic [31:0] rand_word();
		longint v;
		int     r;
		r = $urandom_range(99);
		if (r < 5) begin
			return 32'h7FFF_FFFF;
		end else if (r < 10) begin
			return 32'h8000_0000;
		end else if (r < 35) begin
			return $urandom;
		end
		v = rand_between(-4194304, 4194304);
		return v[31:0];
	endfunction

	// mostly cells near a domain edge, some anywhere
	function automatic item_t rand_point();
		item_t  pt;
		longint d, depth;
		int     side;
		d = (thick == 0) ? 1 : thick;
		if ($urandom_range(99) < 20) begin
			pt.cell_x = 24'($urandom);
			pt.cell_y = 24'($urandom);
		end else begin
			depth = rand_between(-(d / 4), d + d / 4);
			side  = $urandom_range(3);
			pt.cell_x = clamp_coord(rand_between(zmin_x, zmax_x));
			pt.cell_y = clamp_coord(rand_between(zmin_y, zmax_y));
			case (side)
				0: pt.cell_x = clamp_coord(zmin_x + depth);
				1: pt.cell_x = clamp_coord(zmax_x - depth);
				2: pt.cell_y = clamp_coord(zmax_y - depth);
				default: pt.cell_y = clamp_coord(zmin_y + depth);
			endcase
		end
		for (int k = 0; k < FIELD_LANES; k++) begin
			pt.value[k]  = rand_word();
			pt.target[k] = rand_word();
		end
		pt.mode         = 1'($urandom_range(1));
		pt.target_valid = ($urandom_range(99) < 85);
		return pt;
	endfunction

	task automatic test_reset_defaults();
		send_point(mk(1'b0, 1'b1, -256, 0, 32'h0001_0000, 32'h0005_0000));
		send_point(mk(1'b0, 1'b1, 0, 0, 32'h0001_0000, 32'h0005_0000));
		send_point(mk(1'b1, 1'b1, 100, -5000, 32'hFFF0_0000, 32'h0020_0000));
	endtask

	task automatic test_register_map();
		configure(-25600, 25600, -25600, 25600, 15360, 19661, 6554);
		// unknown index must leave every register alone
		write_reg(REG_SPARE, 24'hFFFFFF);
		send_point(mk(1'b0, 1'b1, -25500, 0, 32'h0000_8000, 32'hFFFF_0000));
	endtask

	task automatic test_zone_sorting();
		send_point(mk(1'b0, 1'b1, 0, 0, 32'h0001_0000, 32'h0002_0000));
		send_point(mk(1'b0, 1'b1, -25500, 0, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b0, 1'b1, -10240, 0, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b0, 1'b1, -10239, 300, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b0, 1'b1, -10241, 0, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b0, 1'b1, 25550, 1000, 32'hFF00_0000, 32'h0003_0000));
		send_point(mk(1'b0, 1'b1, 0, 22600, 32'h0010_0000, 32'hFFF0_0000));
		send_point(mk(1'b0, 1'b1, 0, -18600, 32'h1234_5678, 32'h8765_4321));
		send_point(mk(1'b0, 1'b1, -30000, 0, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b0, 1'b1, -25500, -25500, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b0, 1'b0, -25500, 0, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b1, 1'b1, 25000, 0, 32'h0019_0000, 32'h0014_8000));
		send_point(mk(1'b0, 1'b1, COORD_MAX, COORD_MIN, 32'h0000_0001, 32'hFFFF_FFFF));
		send_point(mk(1'b1, 1'b1, COORD_MIN, COORD_MAX, 32'h7FFF_0000, 32'h0000_0000));
	endtask

	task automatic test_saturation();
		settle();
		write_reg(REG_ALPHA_V, 24'h00FFFF);
		write_reg(REG_ALPHA_T, 24'h00FFFF);
		send_point(mk(1'b0, 1'b1, -30000, 0, 32'h8000_0000, 32'h7FFF_FFFF));
		send_point(mk(1'b0, 1'b1, -30000, 0, 32'h7FFF_FFFF, 32'h8000_0000));
		send_point(mk(1'b0, 1'b1, -30000, 0, 32'h0123_4567, 32'h0123_4567));
		send_point(mk(1'b1, 1'b1, -30000, 0, 32'h8000_0000, 32'h7FFF_FFFF));
	endtask

	task automatic test_zero_thickness();
		settle();
		write_reg(REG_THICK, 24'd0);
		send_point(mk(1'b0, 1'b1, -25599, 0, 32'h0001_0000, 32'h0042_0000));
		send_point(mk(1'b0, 1'b1, -25600, 0, 32'h0001_0000, 32'h0042_0000));
	endtask

	task automatic test_random_sweep(input int count);
		repeat (count) send_point(rand_point());
	endtask

	task automatic test_random_settings(input int rounds, input int count);
		longint mnx, mny;
		repeat (rounds) begin
			mnx = rand_between(-4000000, 1000000);
			mny = rand_between(-4000000, 1000000);
			configure(mnx, mnx + rand_between(1, 3000000), mny, mny + rand_between(1, 3000000),
				rand_between(1, 2000000), $urandom_range(65535), $urandom_range(65535));
			test_random_sweep(count);
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		no_idle       = 1'b0;
		mismatches    = 0;
		cells_in      = 0;
		results_out   = 0;
		applied       = 0;
		settings_used = 1;
		for (int z = 0; z < 5; z++) begin
			zone_hits[z] = 0;
		end
		zmin_x    = 0;
		zmax_x    = 0;
		zmin_y    = 0;
		zmax_y    = 0;
		thick     = longint'(THICK_RST);
		gain_vel  = longint'(ALPHA_V_RST);
		gain_temp = longint'(ALPHA_T_RST);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_map();
		test_zone_sorting();
		test_saturation();
		test_zero_thickness();

		configure(-25600, 25600, -25600, 25600, 15360, 19661, 6554);
		test_random_sweep(300);
		configure(-51200, 12800, -20000, 40000, 8000, 40000, 30000);
		no_idle = 1'b1;
		test_random_sweep(300);
		settle();
		no_idle = 1'b0;
		configure(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 8388607, 65535, 0);
		test_random_sweep(250);
		configure(0, 1000, -500, 500, 1, 0, 65535);
		test_random_sweep(250);
		test_random_settings(3, 150);
		configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		test_random_sweep(150);
		configure($urandom, $urandom, $urandom, $urandom, 0, $urandom, $urandom);
		test_random_sweep(100);

		settle();
		repeat (4 * LATENCY) @(posedge clk);
		if (pending_sources.size() != 0) begin
			report_mismatch("sources never delivered", 0, pending_sources.size());
		end
		$display("Run covered %0d cells and %0d results over %0d register settings, %0d applied.",
			cells_in, results_out, settings_used, applied);
		$display("Zones seen: none %0d, west %0d, east %0d, north %0d, south %0d.",
			zone_hits[0], zone_hits[1], zone_hits[2], zone_hits[3], zone_hits[4]);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("Timeout with %0d sources pending", pending_sources.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
